[sv/sleep_stage_tracker_unit_defines.svh]
// assertion macros for the sleep stage tracker
`ifndef SLEEP_STAGE_TRACKER_UNIT_DEFINES_SVH
`define SLEEP_STAGE_TRACKER_UNIT_DEFINES_SVH

// same-cycle implication
`define SST_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SST_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/sst_pkg.sv]
`timescale 1ns / 1ps
package sst_pkg;

  localparam int MotionHoursDef = 6;

  localparam int unsigned WinStart    = 20;
  localparam int unsigned WinEnd      = 8;
  localparam int unsigned StillThresh = 120;
  localparam int unsigned MoveThresh  = 200;
  localparam int unsigned LongStill   = 3600 * 2;
  localparam int unsigned DeepStill   = 60 * 10;
  localparam int unsigned SedLimit    = 180;
  localparam int unsigned MinStill    = 60;
  localparam int unsigned PhaseLen    = 60;

  localparam int PaddrW = 4;
  localparam int PdataW = 32;

  typedef enum logic [1:0] {
    REG_LIGHT_START = 2'd0,
    REG_DEEP_START  = 2'd1,
    REG_QUIET_LIMIT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [15:0]        step_count;
    logic [7:0]         heart_rate;
    logic [4:0]         hour_of_day;
    logic               charging;
    logic               worn;
  } in_item_t;

  typedef struct packed {
    logic [15:0] light_total;
    logic [15:0] deep_total;
    logic [15:0] light_minutes;
    logic [15:0] deep_minutes;
  } res_item_t;

  typedef struct packed {
    logic        light_we;
    logic        deep_we;
    logic [15:0] light_val;
    logic [15:0] deep_val;
    logic [2:0]  quiet_limit;
  } cfg_ctl_t;

endpackage

[sv/sst_in_if.sv]
`timescale 1ns / 1ps
interface sst_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic [15:0]        step_count;
  logic [7:0]         heart_rate;
  logic [4:0]         hour_of_day;
  logic               charging;
  logic               worn;

  modport source (
    output valid, accel_x, accel_y, accel_z, step_count, heart_rate, hour_of_day,
           charging, worn,
    input  ready
  );
  modport sink (
    input  valid, accel_x, accel_y, accel_z, step_count, heart_rate, hour_of_day,
           charging, worn,
    output ready
  );
endinterface

[sv/sst_out_if.sv]
`timescale 1ns / 1ps
interface sst_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] light_total;
  logic [15:0] deep_total;
  logic [15:0] light_minutes;
  logic [15:0] deep_minutes;

  modport source (
    output valid, light_total, deep_total, light_minutes, deep_minutes,
    input  ready
  );
  modport sink (
    input  valid, light_total, deep_total, light_minutes, deep_minutes,
    output ready
  );
endinterface

[sv/sst_cfg_regs.sv]
`timescale 1ns / 1ps
module sst_cfg_regs
  import sst_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output cfg_ctl_t          ctl
);

  logic [15:0] light_start_r;
  logic [15:0] deep_start_r;
  logic [2:0]  quiet_limit_r;
  logic        wr;
  cfg_reg_t    sel;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign sel    = cfg_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_start_r <= '0;
      deep_start_r  <= '0;
      quiet_limit_r <= 3'd7;
    end else if (wr && paddr[1:0] == 2'b00) begin
      unique case (sel)
        REG_LIGHT_START: light_start_r <= pwdata[15:0];
        REG_DEEP_START:  deep_start_r  <= pwdata[15:0];
        REG_QUIET_LIMIT: quiet_limit_r <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (sel)
      REG_LIGHT_START: prdata = {16'd0, light_start_r};
      REG_DEEP_START:  prdata = {16'd0, deep_start_r};
      REG_QUIET_LIMIT: prdata = {29'd0, quiet_limit_r};
      default:         prdata = '0;
    endcase
  end

  assign ctl.light_we    = wr && paddr[1:0] == 2'b00 && sel == REG_LIGHT_START;
  assign ctl.deep_we     = wr && paddr[1:0] == 2'b00 && sel == REG_DEEP_START;
  assign ctl.light_val   = pwdata[15:0];
  assign ctl.deep_val    = pwdata[15:0];
  assign ctl.quiet_limit = quiet_limit_r;

endmodule

[sv/sst_tracker.sv]
`timescale 1ns / 1ps
module sst_tracker
  import sst_pkg::*;
#(
  parameter int MOTION_HOURS = MotionHoursDef
) (
  input  logic       clk,
  input  logic       rst_n,
  sst_in_if.sink     in_ch,
  input  cfg_ctl_t   ctl,
  input  logic       out_free,
  output logic       res_valid,
  output res_item_t  res
);

  in_item_t item_r;
  logic     item_valid_r;
  logic     accept;
  logic     process;

  logic [16:0]             prev_level_r, prev_level_nxt;
  logic [15:0]             still_r, still_nxt;
  logic [15:0]             prev_steps_r, prev_steps_nxt;
  logic                    moving_r, moving_nxt;
  logic [5:0]              phase_r, phase_nxt;
  logic [2:0]              quiet_r, quiet_nxt;
  logic [8:0]              sed_r, sed_nxt;
  logic [MOTION_HOURS-1:0] seen_r, seen_nxt;
  logic [15:0]             light_cnt_r, light_cnt_nxt;
  logic [15:0]             deep_cnt_r, deep_cnt_nxt;
  logic [15:0]             light_off_r, light_off_nxt;
  logic [15:0]             deep_off_r, deep_off_nxt;
  logic [15:0]             light_sum_r, light_sum_nxt;
  logic [15:0]             deep_sum_r, deep_sum_nxt;

  logic signed [17:0] acc_sum;
  logic [17:0]        acc_abs;
  logic [16:0]        level;
  logic [16:0]        diff;
  logic [15:0]        still1;
  logic [8:0]         sed1;
  logic [3:0]         zeros;
  logic [2:0]         quiet1;
  logic [4:0]         hour;
  logic               mark, in_win, early, stepped, clr, cnt;

  assign in_ch.ready = !item_valid_r || out_free;
  assign accept      = in_ch.valid && in_ch.ready;
  assign process     = item_valid_r && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (accept) begin
      item_valid_r <= 1'b1;
    end else if (process) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.accel_x     <= in_ch.accel_x;
      item_r.accel_y     <= in_ch.accel_y;
      item_r.accel_z     <= in_ch.accel_z;
      item_r.step_count  <= in_ch.step_count;
      item_r.heart_rate  <= in_ch.heart_rate;
      item_r.hour_of_day <= in_ch.hour_of_day;
      item_r.charging    <= in_ch.charging;
      item_r.worn        <= in_ch.worn;
    end
  end

  // per-second tracking
  assign hour    = item_r.hour_of_day;
  assign acc_sum = 18'(item_r.accel_x) + 18'(item_r.accel_y) + 18'(item_r.accel_z);
  assign acc_abs = acc_sum[17] ? 18'(-acc_sum) : 18'(acc_sum);
  assign level   = acc_abs[16:0];
  assign diff    = (prev_level_r > level) ? prev_level_r - level : level - prev_level_r;
  assign still1  = (diff >= 17'(StillThresh)) ? 16'd0 :
                   (still_r == 16'hFFFF) ? still_r : still_r + 16'd1;
  assign mark    = (diff >= 17'(MoveThresh) || item_r.heart_rate != 8'd0) &&
                   ({27'd0, hour} < 32'(MOTION_HOURS));
  assign early   = hour < 5'(WinEnd);
  assign in_win  = hour >= 5'(WinStart) || early;
  assign stepped = prev_steps_r < item_r.step_count && prev_steps_r != 16'd0;

  always_comb begin
    seen_nxt = seen_r;
    for (int i = 0; i < MOTION_HOURS; i++) begin
      if (mark && hour == 5'(i)) begin
        seen_nxt[i] = 1'b1;
      end
    end
  end

  always_comb begin
    zeros = '0;
    for (int i = 0; i < MOTION_HOURS; i++) begin
      zeros = zeros + {3'd0, ~seen_nxt[i]};
    end
  end

  // movement flag and sedentary minutes at the minute tick
  always_comb begin
    moving_nxt = moving_r;
    sed1       = sed_r;
    if (stepped || moving_r) begin
      moving_nxt = !moving_r || stepped;
      if (early) begin
        sed1 = (sed_r == 9'h1FF) ? sed_r : sed_r + 9'd1;
      end
    end else if (still1 <= 16'(MinStill)) begin
      if (early) begin
        sed1 = (sed_r == 9'h1FF) ? sed_r : sed_r + 9'd1;
      end else begin
        sed1 = '0;
      end
    end
  end

  assign quiet1 = ({27'd0, hour} >= 32'(MOTION_HOURS) && hour <= 5'(WinEnd) &&
                   quiet_r == 3'd0) ? ((zeros > 4'd7) ? 3'd7 : zeros[2:0]) : quiet_r;
  assign clr    = still1 >= 16'(LongStill) || quiet1 >= ctl.quiet_limit ||
                  (early && sed1 > 9'(SedLimit));
  assign cnt    = prev_steps_r == item_r.step_count && still1 >= 16'(MinStill);

  always_comb begin
    prev_level_nxt = prev_level_r;
    still_nxt      = still_r;
    prev_steps_nxt = prev_steps_r;
    phase_nxt      = phase_r;
    quiet_nxt      = quiet_r;
    sed_nxt        = sed_r;
    light_cnt_nxt  = light_cnt_r;
    deep_cnt_nxt   = deep_cnt_r;
    light_off_nxt  = light_off_r;
    deep_off_nxt   = deep_off_r;
    light_sum_nxt  = light_sum_r;
    deep_sum_nxt   = deep_sum_r;
    res_valid      = 1'b0;
    if (process && !item_r.charging) begin
      prev_level_nxt = level;
      still_nxt      = still1;
      prev_steps_nxt = item_r.step_count;
      phase_nxt      = (phase_r == 6'(PhaseLen - 1)) ? 6'd0 : phase_r + 6'd1;
      if (phase_r == 6'd0) begin
        res_valid = 1'b1;
        sed_nxt   = sed1;
        if (in_win) begin
          quiet_nxt = quiet1;
          if (clr) begin
            sed_nxt       = '0;
            light_cnt_nxt = '0;
            deep_cnt_nxt  = '0;
            light_off_nxt = '0;
            deep_off_nxt  = '0;
            light_sum_nxt = '0;
            deep_sum_nxt  = '0;
          end else if (cnt) begin
            if (item_r.worn) begin
              if (still1 >= 16'(DeepStill)) begin
                deep_cnt_nxt = (deep_cnt_r == 16'hFFFF) ? deep_cnt_r : deep_cnt_r + 16'd1;
              end else begin
                light_cnt_nxt = (light_cnt_r == 16'hFFFF) ? light_cnt_r :
                                light_cnt_r + 16'd1;
              end
            end
            light_sum_nxt = light_cnt_nxt + light_off_r;
            deep_sum_nxt  = deep_cnt_nxt + deep_off_r;
          end
        end else begin
          prev_level_nxt = '0;
          still_nxt      = '0;
          quiet_nxt      = '0;
          sed_nxt        = '0;
          light_cnt_nxt  = '0;
          deep_cnt_nxt   = '0;
          light_off_nxt  = '0;
          deep_off_nxt   = '0;
        end
      end
    end
    if (ctl.light_we) begin
      light_off_nxt = ctl.light_val;
      light_sum_nxt = ctl.light_val;
    end
    if (ctl.deep_we) begin
      deep_off_nxt = ctl.deep_val;
      deep_sum_nxt = ctl.deep_val;
    end
  end

  logic upd, upd_minute, upd_clear;
  assign upd        = process && !item_r.charging;
  assign upd_minute = upd && phase_r == 6'd0;
  assign upd_clear  = upd_minute && !in_win;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r <= '0;
      still_r      <= '0;
      prev_steps_r <= '0;
      moving_r     <= 1'b0;
      phase_r      <= '0;
      quiet_r      <= '0;
      sed_r        <= '0;
      seen_r       <= '0;
      light_cnt_r  <= '0;
      deep_cnt_r   <= '0;
      light_off_r  <= '0;
      deep_off_r   <= '0;
      light_sum_r  <= '0;
      deep_sum_r   <= '0;
    end else begin
      prev_level_r <= prev_level_nxt;
      still_r      <= still_nxt;
      prev_steps_r <= prev_steps_nxt;
      phase_r      <= phase_nxt;
      quiet_r      <= quiet_nxt;
      sed_r        <= sed_nxt;
      light_cnt_r  <= light_cnt_nxt;
      deep_cnt_r   <= deep_cnt_nxt;
      light_off_r  <= light_off_nxt;
      deep_off_r   <= deep_off_nxt;
      light_sum_r  <= light_sum_nxt;
      deep_sum_r   <= deep_sum_nxt;
      if (upd_clear) begin
        moving_r <= 1'b0;
        seen_r   <= '0;
      end else if (upd) begin
        seen_r <= seen_nxt;
        if (upd_minute) begin
          moving_r <= moving_nxt;
        end
      end
    end
  end

  assign res.light_total   = light_sum_nxt;
  assign res.deep_total    = deep_sum_nxt;
  assign res.light_minutes = light_cnt_nxt;
  assign res.deep_minutes  = deep_cnt_nxt;

endmodule

[sv/sst_out_stage.sv]
`timescale 1ns / 1ps
module sst_out_stage
  import sst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      res_valid,
  input  res_item_t res,
  output logic      free,
  sst_out_if.source out_ch
);

  logic      valid_r;
  res_item_t data_r;

  assign free = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free && res_valid) begin
      data_r <= res;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.light_total   = data_r.light_total;
  assign out_ch.deep_total    = data_r.deep_total;
  assign out_ch.light_minutes = data_r.light_minutes;
  assign out_ch.deep_minutes  = data_r.deep_minutes;

endmodule

[sv/sleep_stage_tracker_unit.sv]
`timescale 1ns / 1ps
// Sleep stage tracker. Takes one sensor item per clock (one per second of wear time) and
// reports light and deep sleep minutes, raw and with the restored offsets, once every 60
// non-charging items; items marked charging leave the state untouched and give no result.
// An accepted item is held in the input register, then the whole per-second and
// per-minute update is done combinationally against the state registers, the result is
// registered in the output stage, and a new item can enter every cycle while the result
// side takes items. The offset registers may be written only while no item is in flight;
// a write reloads the matching offset and total.
module sleep_stage_tracker_unit
  import sst_pkg::*;
#(
  parameter int MOTION_HOURS = MotionHoursDef
) (
  input  logic              clk,
  input  logic              rst_n,
  sst_in_if.sink            in_ch,
  sst_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  cfg_ctl_t  ctl;
  logic      out_free;
  logic      res_valid;
  res_item_t res;

  sst_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ctl     (ctl)
  );

  sst_tracker #(
    .MOTION_HOURS (MOTION_HOURS)
  ) u_trk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .ctl       (ctl),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res)
  );

  sst_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .free      (out_free),
    .out_ch    (out_ch)
  );

endmodule

[sv/sst_checker.sv]
`timescale 1ns / 1ps
`include "sleep_stage_tracker_unit_defines.svh"
module sst_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] light_total,
  input logic [15:0] deep_total,
  input logic [15:0] light_minutes,
  input logic [15:0] deep_minutes
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  `SST_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(light_total) && $stable(deep_total) && $stable(light_minutes) && $stable(deep_minutes),
    "stalled result changed")

  `SST_ASSERT_IMP(a_ready_when_empty, !out_valid, in_ready,
    "input stalled with empty output")

  `SST_ASSERT_IMP(a_ready_when_drained, out_ready, in_ready,
    "input stalled while output drains")

  `SST_ASSERT_IMP(a_out_from_item, $rose(out_valid), $past(in_acc, 2),
    "result without an item two cycles earlier")

endmodule

bind sleep_stage_tracker_unit sst_checker u_sst_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .light_total   (out_ch.light_total),
  .deep_total    (out_ch.deep_total),
  .light_minutes (out_ch.light_minutes),
  .deep_minutes  (out_ch.deep_minutes)
);

[dv/sleep_stage_tracker_unit_tb.sv]
`timescale 1ns / 1ps
module sleep_stage_tracker_unit_tb;
  import sst_pkg::*;

  localparam int CycleLimit = 1_000_000;

  typedef enum logic [1:0] {MIN_SLEEP, MIN_ACTIVE, MIN_BROKEN, MIN_NOISE} minute_kind_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic pready;

  sst_in_if in_ch ();
  sst_out_if out_ch ();

  sleep_stage_tracker_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // tracker state mirror
  logic [16:0] lvl_prev;
  logic [15:0] still_cnt, steps_prev;
  logic moving;
  logic [5:0] phase;
  logic [2:0] quiet_cnt;
  logic [8:0] sed_min;
  logic [MotionHoursDef-1:0] hour_marks;
  logic [15:0] light_cnt, deep_cnt, light_off, deep_off, light_tot, deep_tot;
  logic [2:0] quiet_limit;

  res_item_t sleep_totals_q[$];
  res_item_t want_totals;
  int err_count = 0;
  int cycle_count = 0;
  int hold_left = 0;
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;
  int unsigned rest_level;
  logic [15:0] step_total;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t: %s got %0d expected %0d", $time, what, got, want);
    err_count++;
  endtask

  task automatic clear_tracker();
    lvl_prev = '0;
    still_cnt = '0;
    steps_prev = '0;
    moving = 1'b0;
    phase = '0;
    quiet_cnt = '0;
    sed_min = '0;
    hour_marks = '0;
    light_cnt = '0;
    deep_cnt = '0;
    light_off = '0;
    deep_off = '0;
    light_tot = '0;
    deep_tot = '0;
    quiet_limit = 3'd7;
  endtask

  function automatic bit advance_tracker(input in_item_t s, output res_item_t r);
    int sum;
    int unsigned lvl, dif;
    bit stepped, tick;
    r = '0;
    if (s.charging) return 1'b0;
    sum = int'($signed(s.accel_x)) + int'($signed(s.accel_y)) + int'($signed(s.accel_z));
    lvl = (sum < 0) ? -sum : sum;
    dif = (lvl_prev > lvl) ? lvl_prev - lvl : lvl - lvl_prev;
    if (dif >= StillThresh) still_cnt = '0;
    else if (still_cnt != 16'hFFFF) still_cnt = still_cnt + 1'b1;
    if ((dif >= MoveThresh || s.heart_rate != 0) && s.hour_of_day < MotionHoursDef)
      hour_marks[s.hour_of_day] = 1'b1;
    lvl_prev = lvl[16:0];
    tick = (phase == 0);
    if (tick) begin
      stepped = (steps_prev < s.step_count) && (steps_prev != 0);
      if (stepped || moving) begin
        moving = !moving || stepped;
        if (s.hour_of_day < WinEnd && sed_min != 9'h1FF) sed_min = sed_min + 1'b1;
      end else if (still_cnt <= MinStill) begin
        if (s.hour_of_day < WinEnd) begin
          if (sed_min != 9'h1FF) sed_min = sed_min + 1'b1;
        end else begin
          sed_min = '0;
        end
      end
      if (s.hour_of_day >= WinStart || s.hour_of_day < WinEnd) begin
        if (s.hour_of_day >= MotionHoursDef && s.hour_of_day <= WinEnd && quiet_cnt == 0) begin
          for (int i = 0; i < MotionHoursDef; i++)
            if (!hour_marks[i] && quiet_cnt != 3'd7) quiet_cnt = quiet_cnt + 1'b1;
        end
        if (still_cnt >= LongStill || quiet_cnt >= quiet_limit ||
            (s.hour_of_day < WinEnd && sed_min > SedLimit)) begin
          sed_min = '0;
          light_cnt = '0;
          deep_cnt = '0;
          light_off = '0;
          deep_off = '0;
          light_tot = '0;
          deep_tot = '0;
        end else if (steps_prev == s.step_count && still_cnt >= MinStill) begin
          if (s.worn) begin
            if (still_cnt >= DeepStill) begin
              if (deep_cnt != 16'hFFFF) deep_cnt = deep_cnt + 1'b1;
            end else if (light_cnt != 16'hFFFF) begin
              light_cnt = light_cnt + 1'b1;
            end
          end
          light_tot = light_cnt + light_off;
          deep_tot = deep_cnt + deep_off;
        end
      end else begin
        // out of the night window: tracking restarts, totals stay
        lvl_prev = '0;
        phase = '0;
        moving = 1'b0;
        still_cnt = '0;
        quiet_cnt = '0;
        light_off = '0;
        deep_off = '0;
        light_cnt = '0;
        deep_cnt = '0;
        sed_min = '0;
        hour_marks = '0;
      end
      r.light_total = light_tot;
      r.deep_total = deep_tot;
      r.light_minutes = light_cnt;
      r.deep_minutes = deep_cnt;
    end
    phase = (phase == PhaseLen - 1) ? '0 : phase + 1'b1;
    steps_prev = s.step_count;
    return tick;
  endfunction

  // result side
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !(stalls_on && $urandom_range(99) < 23);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (sleep_totals_q.size() == 0) begin
        report_mismatch("result with none pending, light_total", out_ch.light_total, 0);
      end else begin
        want_totals = sleep_totals_q.pop_front();
        if (out_ch.light_total !== want_totals.light_total)
          report_mismatch("light_total", out_ch.light_total, want_totals.light_total);
        if (out_ch.deep_total !== want_totals.deep_total)
          report_mismatch("deep_total", out_ch.deep_total, want_totals.deep_total);
        if (out_ch.light_minutes !== want_totals.light_minutes)
          report_mismatch("light_minutes", out_ch.light_minutes, want_totals.light_minutes);
        if (out_ch.deep_minutes !== want_totals.deep_minutes)
          report_mismatch("deep_minutes", out_ch.deep_minutes, want_totals.deep_minutes);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_sample(input in_item_t s);
    res_item_t r;
    while (gaps_on && $urandom_range(99) < 23) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.accel_x <= s.accel_x;
    in_ch.accel_y <= s.accel_y;
    in_ch.accel_z <= s.accel_z;
    in_ch.step_count <= s.step_count;
    in_ch.heart_rate <= s.heart_rate;
    in_ch.hour_of_day <= s.hour_of_day;
    in_ch.charging <= s.charging;
    in_ch.worn <= s.worn;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (advance_tracker(s, r)) sleep_totals_q.push_back(r);
  endtask

  task automatic send_fields(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z,
                             input logic [15:0] steps, input logic [7:0] hr,
                             input logic [4:0] hour, input logic chg, input logic worn);
    in_item_t s;
    s.accel_x = x;
    s.accel_y = y;
    s.accel_z = z;
    s.step_count = steps;
    s.heart_rate = hr;
    s.hour_of_day = hour;
    s.charging = chg;
    s.worn = worn;
    send_sample(s);
  endtask

  // splits a motion level over the three axes with random cancelling parts
  function automatic in_item_t make_sample(input int unsigned lvl, input logic [15:0] steps,
                                           input logic [7:0] hr, input logic [4:0] hour,
                                           input logic worn, input logic chg);
    in_item_t s;
    int a, x, y, z;
    a = int'($urandom_range(32000)) - 16000;
    x = a;
    y = int'(lvl / 2) - a;
    z = int'(lvl) - int'(lvl / 2);
    if ($urandom_range(1)) begin
      x = -x;
      y = -y;
      z = -z;
    end
    s.accel_x = x[15:0];
    s.accel_y = y[15:0];
    s.accel_z = z[15:0];
    s.step_count = steps;
    s.heart_rate = hr;
    s.hour_of_day = hour;
    s.charging = chg;
    s.worn = worn;
    return s;
  endfunction

  task automatic send_minute(input minute_kind_t kind, input logic [4:0] hour);
    in_item_t s;
    logic [95:0] raw;
    int k;
    for (k = 0; k < 60; k++) begin
      case (kind)
        MIN_SLEEP: begin
          s = make_sample(rest_level + $urandom_range(100), step_total,
                          ($urandom_range(19) == 0) ? 8'($urandom_range(255, 1)) : 8'd0,
                          hour, $urandom_range(9) != 0, 1'b0);
        end
        MIN_ACTIVE: begin
          if ($urandom_range(2) == 0) step_total = step_total + 16'($urandom_range(4, 1));
          s = make_sample($urandom_range(32000), step_total, 8'($urandom_range(255, 40)),
                          hour, 1'b1, 1'b0);
        end
        MIN_BROKEN: begin
          if ($urandom_range(9) == 0) step_total = step_total + 1'b1;
          s = make_sample(rest_level + $urandom_range(100), step_total, 8'd0, hour, 1'b1,
                          $urandom_range(6) == 0);
        end
        default: begin
          raw = {$urandom, $urandom, $urandom};
          s = raw[$bits(in_item_t)-1:0];
          s.charging = ($urandom_range(3) == 0);
        end
      endcase
      send_sample(s);
    end
  endtask

  // no item in flight: results drained plus pipeline latency
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sleep_totals_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PaddrW'({idx, 2'b00});
    pwdata <= PdataW'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_LIGHT_START: begin
        light_off = val;
        light_tot = val;
      end
      REG_DEEP_START: begin
        deep_off = val;
        deep_tot = val;
      end
      default: quiet_limit = val[2:0];
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] light, input logic [15:0] deep,
                            input logic [2:0] limit);
    settle();
    write_reg(REG_LIGHT_START, light);
    write_reg(REG_DEEP_START, deep);
    write_reg(REG_QUIET_LIMIT, 16'(limit));
  endtask

  task automatic test_directed();
    send_fields(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 8'hFF, 5'd31, 1'b0, 1'b1);
    send_fields(16'h8000, 16'h8000, 16'h8000, 16'h0000, 8'h00, 5'd0, 1'b0, 1'b0);
    send_fields(16'h0000, 16'h0000, 16'h0000, 16'h0001, 8'h00, 5'd24, 1'b0, 1'b1);
    send_fields(16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 8'h80, 5'd3, 1'b1, 1'b1);
    send_fields(16'h0010, 16'h0020, 16'h0030, 16'h0001, 8'h01, 5'd5, 1'b0, 1'b1);
    send_fields(16'h00C8, 16'h0000, 16'h0000, 16'h0001, 8'h00, 5'd1, 1'b0, 1'b1);
    send_fields(16'h0000, 16'h0000, 16'h0000, 16'h0002, 8'h00, 5'd6, 1'b0, 1'b1);
    send_fields(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0002, 8'h00, 5'd7, 1'b0, 1'b0);
    send_fields(16'h0077, 16'h0000, 16'h0000, 16'h0002, 8'h00, 5'd8, 1'b0, 1'b1);
    send_fields(16'h5555, 16'hAAAA, 16'h1234, 16'h5555, 8'h55, 5'd19, 1'b0, 1'b1);
    send_fields(16'hAAAA, 16'h5555, 16'hEDCB, 16'hAAAA, 8'hAA, 5'd20, 1'b0, 1'b1);
    send_fields(16'h0000, 16'h0000, 16'h0000, 16'hAAAA, 8'h00, 5'd23, 1'b1, 1'b0);
    send_fields(16'h0001, 16'h0000, 16'h0000, 16'hAAAA, 8'h00, 5'd16, 1'b0, 1'b1);
    send_fields(16'h7FFF, 16'h7FFF, 16'h8000, 16'h0000, 8'hFF, 5'd2, 1'b0, 1'b0);
    send_fields(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 8'h00, 5'd4, 1'b0, 1'b1);
  endtask

  // one still stretch of night, long enough for light sleep to turn deep
  task automatic test_long_stillness();
    int m;
    set_config(16'h1234, 16'hFFF0, 3'd7);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    rest_level = 500;
    step_total = 16'd777;
    for (m = 0; m < 12; m++) send_minute(MIN_SLEEP, 5'd22);
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  task automatic test_night_phases();
    int p, m, idx;
    int unsigned pick;
    logic [4:0] hour;
    minute_kind_t kind;
    for (p = 0; p < 4; p++) begin
      case (p)
        0: set_config(16'h0000, 16'h0000, 3'd0);
        1: set_config(16'hFFFF, 16'hFFFF, 3'd7);
        default: set_config(16'($urandom), 16'($urandom), 3'($urandom_range(7)));
      endcase
      rest_level = $urandom_range(31000);
      step_total = 16'($urandom);
      idx = $urandom_range(15);
      for (m = 0; m < 2; m++) begin
        if (idx < 13) hour = 5'((20 + idx) % 24);
        else if ($urandom_range(1)) hour = 5'($urandom_range(31, 24));
        else hour = 5'($urandom_range(19, 9));
        pick = $urandom_range(99);
        kind = (pick < 50) ? MIN_SLEEP : (pick < 70) ? MIN_ACTIVE :
               (pick < 85) ? MIN_BROKEN : MIN_NOISE;
        send_minute(kind, hour);
        if ($urandom_range(1)) idx = (idx + 1) % 16;
      end
    end
  endtask

  // receiver holds off long enough for minute results to back up
  task automatic test_backpressure();
    set_config(16'($urandom), 16'($urandom), 3'($urandom_range(7)));
    rest_level = $urandom_range(31000);
    hold_left = 600;
    send_minute(MIN_SLEEP, 5'd23);
    send_minute(MIN_ACTIVE, 5'd0);
    send_minute(MIN_SLEEP, 5'd1);
  endtask

  initial begin
    int n;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.accel_x = '0;
    in_ch.accel_y = '0;
    in_ch.accel_z = '0;
    in_ch.step_count = '0;
    in_ch.heart_rate = '0;
    in_ch.hour_of_day = '0;
    in_ch.charging = 1'b0;
    in_ch.worn = 1'b0;
    out_ch.ready = 1'b0;
    rest_level = 0;
    step_total = 16'd1;
    clear_tracker();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_long_stillness();
    test_night_phases();
    test_backpressure();

    in_ch.valid <= 1'b0;
    for (n = 0; n < 5000 && sleep_totals_q.size() != 0; n++) @(posedge clk);
    if (sleep_totals_q.size() != 0)
      report_mismatch("results never delivered", 0, sleep_totals_q.size());
    repeat (10) @(posedge clk);
    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/sst_pkg.sv
sv/sst_in_if.sv
sv/sst_out_if.sv
sv/sst_cfg_regs.sv
sv/sst_tracker.sv
sv/sst_out_stage.sv
sv/sleep_stage_tracker_unit.sv
sv/sst_checker.sv
dv/sleep_stage_tracker_unit_tb.sv
